[rtl/ssd_pkg.sv]
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared codes and types of the swap slot directory: operation and status
// codes, and the result of the per-slot compare unit.
// ----------------------------------------------------------------------------
package ssd_pkg;

	localparam logic [1:0] OP_ADD     = 2'd0;
	localparam logic [1:0] OP_LOOKUP  = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_FULL      = 2'd2;

	// Verdict of the compare unit on one slot entry against the search key.
	typedef struct packed {
		logic key_hit;    // valid, same owner and same page
		logic owner_hit;  // valid and same owner
		logic free;       // slot not in use
	} cmp_res_t;

endpackage

[rtl/ssd_ram.sv]
// ----------------------------------------------------------------------------
// ssd_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module ssd_ram #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[rtl/ssd_cmp.sv]
// ----------------------------------------------------------------------------
// ssd_cmp
// Compare unit shared by every search: judges one slot entry against the
// owner and page of the word being processed.
// ----------------------------------------------------------------------------
module ssd_cmp
	import ssd_pkg::*;
#(
	parameter int OWNER_BITS = 8,
	parameter int PAGE_BITS  = 16
) (
	input  logic                  entry_valid,
	input  logic [OWNER_BITS-1:0] entry_owner,
	input  logic [PAGE_BITS-1:0]  entry_page,
	input  logic [OWNER_BITS-1:0] key_owner,
	input  logic [PAGE_BITS-1:0]  key_page,
	output cmp_res_t              res
);

	logic owner_eq;

	assign owner_eq      = (entry_owner == key_owner);
	assign res.owner_hit = entry_valid && owner_eq;
	assign res.key_hit   = entry_valid && owner_eq && (entry_page == key_page);
	assign res.free      = !entry_valid;

endmodule

[rtl/swap_slot_directory_unit.sv]
// ----------------------------------------------------------------------------
// swap_slot_directory_unit
// Directory of swap slots, each holding a valid bit, an owner id and a
// virtual page number, searched one slot per clock.
// ----------------------------------------------------------------------------
// Usage
// The slave stream carries one request word: the operation in s_tuser, owner
// and page in s_tdata. The master stream returns one result word per request:
// slot index, a was-present flag and a status code.
// Add returns an existing matching slot or claims the lowest free one; lookup
// returns the lowest matching slot; release frees every slot of an owner.
// After reset the block clears every slot of the memory with s_tready low;
// it then accepts a word.
// Each request scans every slot through the single RAM read port and the one
// compare unit: the reads, the last compare and a check that the read
// pipeline is empty, after which the result is posted. s_tready is high only
// between requests. The result sits in an output register, so the next
// request may be taken while m_tready is low; a further result then waits
// until the earlier one has been taken.
// ----------------------------------------------------------------------------
module swap_slot_directory_unit
	import ssd_pkg::*;
#(
	parameter int SLOTS      = 512,
	parameter int OWNER_BITS = 8,
	parameter int PAGE_BITS  = 16
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                           s_tvalid,
	output logic                                           s_tready,
	// owner_id, page_number (low bit up), zero filled
	input  logic [((OWNER_BITS+PAGE_BITS+7)/8)*8-1:0]      s_tdata,
	// operation
	input  logic [1:0]                                     s_tuser,

	output logic                                           m_tvalid,
	input  logic                                           m_tready,
	// slot_index, was_present, status (low bit up), zero filled
	output logic [(($clog2(SLOTS)+3+7)/8)*8-1:0]           m_tdata
);

	localparam int SLOT_BITS = $clog2(SLOTS);
	localparam int CNT_W     = $clog2(SLOTS + 1);
	localparam int ENTRY_W   = 1 + OWNER_BITS + PAGE_BITS;
	localparam int OUT_W     = ((SLOT_BITS + 3 + 7) / 8) * 8;

	typedef enum logic [3:0] {
		S_CLEAR = 4'b0001,
		S_IDLE  = 4'b0010,
		S_SCAN  = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  rd_vld_s1;
	logic [SLOT_BITS-1:0]  rd_addr_s1;
	logic [1:0]            op_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [PAGE_BITS-1:0]  page_q;
	logic                  match_found_q;
	logic [SLOT_BITS-1:0]  match_idx_q;
	logic                  free_found_q;
	logic [SLOT_BITS-1:0]  free_idx_q;
	logic                  m_tvalid_q;
	logic [SLOT_BITS-1:0]  m_slot_q;
	logic                  m_present_q;
	logic [1:0]            m_status_q;

	logic                  ram_we;
	logic [SLOT_BITS-1:0]  ram_waddr;
	logic [ENTRY_W-1:0]    ram_wdata;
	logic [SLOT_BITS-1:0]  ram_raddr;
	logic [ENTRY_W-1:0]    ram_rdata;
	cmp_res_t              cmp_res;

	logic                  issue;
	logic                  out_free;
	logic                  alloc;
	logic                  accept;
	logic                  post;
	logic [SLOT_BITS-1:0]  res_slot;
	logic                  res_present;
	logic [1:0]            res_status;

	ssd_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	ssd_cmp #(
		.OWNER_BITS(OWNER_BITS),
		.PAGE_BITS (PAGE_BITS)
	) u_cmp (
		.entry_valid(ram_rdata[ENTRY_W-1]),
		.entry_owner(ram_rdata[OWNER_BITS+PAGE_BITS-1:PAGE_BITS]),
		.entry_page (ram_rdata[PAGE_BITS-1:0]),
		.key_owner  (owner_q),
		.key_page   (page_q),
		.res        (cmp_res)
	);

	assign s_tready  = (state_q == S_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign issue     = (state_q == S_SCAN) && (cnt_q < CNT_W'(SLOTS));
	assign ram_raddr = cnt_q[SLOT_BITS-1:0];
	assign out_free  = !m_tvalid_q || m_tready;
	assign post      = (state_q == S_DONE) && out_free;
	assign alloc     = (op_q == OP_ADD) && !match_found_q && free_found_q;

	always_comb begin
		res_slot    = '0;
		res_present = 1'b0;
		res_status  = STAT_OK;
		case (op_q)
			OP_ADD: begin
				if (match_found_q) begin
					res_slot    = match_idx_q;
					res_present = 1'b1;
				end else if (free_found_q) begin
					res_slot = free_idx_q;
				end else begin
					res_status = STAT_FULL;
				end
			end
			OP_LOOKUP: begin
				if (match_found_q) begin
					res_slot    = match_idx_q;
					res_present = 1'b1;
				end else begin
					res_status = STAT_NOT_FOUND;
				end
			end
			default: begin
				res_status = STAT_OK;
			end
		endcase
	end

	// One write port serves the clearing pass, release and allocation.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_addr_s1;
		ram_wdata = {1'b0, ram_rdata[ENTRY_W-2:0]};
		case (state_q)
			S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q[SLOT_BITS-1:0];
				ram_wdata = '0;
			end
			S_SCAN: begin
				ram_we = rd_vld_s1 && (op_q == OP_RELEASE) && cmp_res.owner_hit;
			end
			S_DONE: begin
				ram_we    = post && alloc;
				ram_waddr = free_idx_q;
				ram_wdata = {1'b1, owner_q, page_q};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			cnt_q         <= '0;
			rd_vld_s1     <= 1'b0;
			match_found_q <= 1'b0;
			free_found_q  <= 1'b0;
			m_tvalid_q    <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					if (cnt_q == CNT_W'(SLOTS - 1)) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				S_IDLE: begin
					if (accept) begin
						cnt_q         <= '0;
						match_found_q <= 1'b0;
						free_found_q  <= 1'b0;
						state_q       <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (issue) begin
						cnt_q <= cnt_q + 1'b1;
					end
					rd_vld_s1 <= issue;
					if (rd_vld_s1 && cmp_res.key_hit) begin
						match_found_q <= 1'b1;
					end
					if (rd_vld_s1 && cmp_res.free) begin
						free_found_q <= 1'b1;
					end
					// The read pipeline has drained once nothing is issued or in flight.
					if (!issue && !rd_vld_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase

			if (post) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= s_tuser;
			owner_q <= s_tdata[OWNER_BITS-1:0];
			page_q  <= s_tdata[OWNER_BITS+PAGE_BITS-1:OWNER_BITS];
		end
		rd_addr_s1 <= cnt_q[SLOT_BITS-1:0];
		// Only the first hit and the first free slot are kept: lowest index wins.
		if (state_q == S_SCAN && rd_vld_s1) begin
			if (cmp_res.key_hit && !match_found_q) begin
				match_idx_q <= rd_addr_s1;
			end
			if (cmp_res.free && !free_found_q) begin
				free_idx_q <= rd_addr_s1;
			end
		end
		if (post) begin
			m_slot_q    <= res_slot;
			m_present_q <= res_present;
			m_status_q  <= res_status;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({m_status_q, m_present_q, m_slot_q});

endmodule

[rtl/ssd_checker.sv]
// ----------------------------------------------------------------------------
// ssd_checker
// Port-level checks on the swap slot directory, bound to the top level.
// ----------------------------------------------------------------------------
module ssd_checker
	import ssd_pkg::*;
#(
	parameter int SLOTS = 512
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  s_tvalid,
	input logic                                  s_tready,
	input logic                                  m_tvalid,
	input logic                                  m_tready,
	input logic [(($clog2(SLOTS)+3+7)/8)*8-1:0]  m_tdata
);

	localparam int SLOT_BITS = $clog2(SLOTS);

	logic [SLOT_BITS-1:0] slot;
	logic                 present;
	logic [1:0]           status;

	assign slot    = m_tdata[SLOT_BITS-1:0];
	assign present = m_tdata[SLOT_BITS];
	assign status  = m_tdata[SLOT_BITS+2:SLOT_BITS+1];

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// One request at a time: a scan follows every accepted word.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted during a scan");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (status == STAT_OK) || (status == STAT_NOT_FOUND) ||
			(status == STAT_FULL))
		else $error("unknown status code");

	// A miss or a full table reports slot zero and no hit.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status != STAT_OK |-> slot == '0 && !present)
		else $error("failed request carries a slot");

	a_hit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && present |-> status == STAT_OK)
		else $error("hit reported with an error status");

endmodule

bind swap_slot_directory_unit ssd_checker #(
	.SLOTS(SLOTS)
) u_ssd_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata)
);

[tb/swap_slot_directory_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swap_slot_directory_unit_test
// Self-checking bench for the swap slot directory. A queue of request words
// feeds a stream driver, and a shadow copy of the directory predicts every
// result word, which a monitor checks field by field. A directed opening is
// followed by random traffic that fills the table, holds it full and then
// mixes adds, lookups and releases, with random gaps on both streams.
// ----------------------------------------------------------------------------
module swap_slot_directory_unit_test;
	import ssd_pkg::*;

	localparam int          SLOT_COUNT    = 512;
	localparam logic [1:0]  OP_SPARE      = 2'd3;
	localparam int          RANDOM_WORDS  = 1100;
	localparam int          FULL_HOLD     = 60;
	localparam int          STALL_AT      = 150;
	localparam int          STALL_CYCLES  = 3000;
	localparam int          DRAIN_CYCLES  = 600;
	localparam longint      CYCLE_LIMIT   = 6000000;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  owner;
		logic [15:0] page;
	} request_t;

	typedef struct packed {
		logic [8:0] slot;
		logic       present;
		logic [1:0] status;
	} outcome_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;

	// Shadow copy of the directory.
	logic        dir_valid [SLOT_COUNT];
	logic [7:0]  dir_owner [SLOT_COUNT];
	logic [15:0] dir_page  [SLOT_COUNT];
	int          slots_in_use = 0;

	request_t    pending_requests[$];
	outcome_t    expected_outcomes[$];
	request_t    known_keys[$];
	request_t    offered;

	int unsigned total_words = 0;
	int unsigned accepted_count = 0;
	int unsigned taken_count = 0;
	int unsigned send_gap = 0;
	int unsigned recv_hold = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	logic        long_hold = 1'b0;
	int unsigned mismatches = 0;
	longint      cycle_count = 0;

	swap_slot_directory_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Updates the shadow directory with one request and queues its result.
	task automatic apply_request(input request_t rq);
		outcome_t oc;
		int       hit;
		int       spare;
		oc = '0;
		oc.status = STAT_OK;
		hit = -1;
		spare = -1;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (dir_valid[i] && dir_owner[i] == rq.owner && dir_page[i] == rq.page)
				hit = i;
			if (!dir_valid[i])
				spare = i;
		end
		case (rq.op)
			OP_ADD: begin
				if (hit >= 0) begin
					oc.slot = 9'(hit);
					oc.present = 1'b1;
				end else if (spare >= 0) begin
					dir_valid[spare] = 1'b1;
					dir_owner[spare] = rq.owner;
					dir_page[spare] = rq.page;
					slots_in_use++;
					oc.slot = 9'(spare);
				end else begin
					oc.status = STAT_FULL;
				end
			end
			OP_LOOKUP: begin
				if (hit >= 0) begin
					oc.slot = 9'(hit);
					oc.present = 1'b1;
				end else begin
					oc.status = STAT_NOT_FOUND;
				end
			end
			OP_RELEASE: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (dir_valid[i] && dir_owner[i] == rq.owner) begin
						dir_valid[i] = 1'b0;
						slots_in_use--;
					end
				end
			end
			default: ;
		endcase
		expected_outcomes.push_back(oc);
	endtask

	// Mostly back to back, now and then a long pause.
	function automatic int unsigned draw_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 6);
		else if (r < 98)
			return $urandom_range(7, 40);
		return $urandom_range(41, 300);
	endfunction

	// A set of 24 busy owners, with an arbitrary one mixed in.
	function automatic logic [7:0] draw_owner();
		if ($urandom_range(0, 9) < 7)
			return 8'($urandom_range(0, 23) * 11);
		return 8'($urandom);
	endfunction

	function automatic request_t draw_known(input logic [1:0] op);
		request_t rq;
		rq = known_keys[$urandom_range(0, known_keys.size() - 1)];
		rq.op = op;
		return rq;
	endfunction

	task automatic queue_request(input logic [1:0] op, input logic [7:0] owner,
			input logic [15:0] page);
		request_t rq;
		rq.op = op;
		rq.owner = owner;
		rq.page = page;
		pending_requests.push_back(rq);
		total_words++;
		if (op == OP_ADD) begin
			known_keys.push_back(rq);
			if (known_keys.size() > 600)
				void'(known_keys.pop_front());
		end
	endtask

	// Stream driver: a word stays offered until it is taken.
	always @(posedge clk) begin : drive
		logic offer;
		logic calm;
		offer = s_tvalid;
		calm = (accepted_count % 256) >= 200;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				apply_request(offered);
				accepted_count++;
				send_gap = calm ? 0 : draw_gap();
				offer = 1'b0;
			end
			if (!offer) begin
				if (send_gap > 0) begin
					send_gap--;
				end else if (pending_requests.size() > 0) begin
					offered = pending_requests.pop_front();
					s_tdata <= {offered.page, offered.owner};
					s_tuser <= offered.op;
					offer = 1'b1;
				end
			end
		end
		s_tvalid <= offer;
	end

	// One long hold-off of the receiver lets the block fill up and stall its input.
	always @(posedge clk) begin : hold_off
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				hold_seen++;
				if (hold_seen == STALL_AT)
					hold_left = STALL_CYCLES;
			end
			if (hold_left > 0)
				hold_left--;
		end
		long_hold <= (hold_left > 0);
	end

	// Result monitor, which also paces m_tready.
	always @(posedge clk) begin : observe
		outcome_t want;
		logic     ready;
		logic     calm;
		ready = m_tready;
		calm = (taken_count % 256) >= 200;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				taken_count++;
				if (expected_outcomes.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result word %h", $time, m_tdata);
				end else begin
					want = expected_outcomes.pop_front();
					if (m_tdata[8:0] !== want.slot) begin
						mismatches++;
						$display("%0t: slot_index expected %0d actual %0d",
							$time, want.slot, m_tdata[8:0]);
					end
					if (m_tdata[9] !== want.present) begin
						mismatches++;
						$display("%0t: was_present expected %0d actual %0d",
							$time, want.present, m_tdata[9]);
					end
					if (m_tdata[11:10] !== want.status) begin
						mismatches++;
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, m_tdata[11:10]);
					end
				end
				recv_hold = calm ? 0 : draw_gap();
			end
			if (long_hold) begin
				ready = 1'b0;
			end else if (recv_hold > 0) begin
				recv_hold--;
				ready = 1'b0;
			end else begin
				ready = 1'b1;
			end
		end
		m_tready <= ready;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		int unsigned r;
		int unsigned full_left;
		bit          filled;
		request_t    rq;
		full_left = FULL_HOLD;
		filled = 1'b0;
		for (int i = 0; i < SLOT_COUNT; i++)
			dir_valid[i] = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening.
		queue_request(OP_LOOKUP,  8'd0,   16'd0);
		queue_request(OP_ADD,     8'd0,   16'd0);
		queue_request(OP_ADD,     8'd255, 16'hFFFF);
		queue_request(OP_ADD,     8'd0,   16'd0);
		queue_request(OP_LOOKUP,  8'd255, 16'hFFFF);
		queue_request(OP_LOOKUP,  8'd255, 16'd0);
		queue_request(OP_LOOKUP,  8'd0,   16'hFFFF);
		queue_request(OP_ADD,     8'd0,   16'd1);
		queue_request(OP_SPARE,   8'd0,   16'd0);
		queue_request(OP_LOOKUP,  8'd0,   16'd0);
		// The page of a release word is ignored.
		queue_request(OP_RELEASE, 8'd0,   16'hABCD);
		queue_request(OP_LOOKUP,  8'd0,   16'd0);
		queue_request(OP_ADD,     8'd170, 16'h5555);
		queue_request(OP_ADD,     8'd85,  16'hAAAA);
		queue_request(OP_LOOKUP,  8'd255, 16'hFFFF);
		queue_request(OP_RELEASE, 8'd255, 16'h0000);
		queue_request(OP_RELEASE, 8'd255, 16'hFFFF);
		queue_request(OP_SPARE,   8'd255, 16'hFFFF);
		queue_request(OP_ADD,     8'd255, 16'hFFFF);
		queue_request(OP_LOOKUP,  8'd170, 16'h5555);

		// Random traffic: fill the table, keep it full for a while, then mix.
		for (int n = 0; n < RANDOM_WORDS; n++) begin
			while (pending_requests.size() >= 2)
				@(posedge clk);
			if (slots_in_use == SLOT_COUNT)
				filled = 1'b1;
			r = $urandom_range(0, 99);
			if (!filled) begin
				if (r < 92) begin
					if ($urandom_range(0, 9) == 0)
						rq = draw_known(OP_ADD);
					else
						rq = '{OP_ADD, draw_owner(), 16'($urandom)};
				end else if (r < 97) begin
					rq = draw_known(OP_LOOKUP);
				end else if (r < 98) begin
					rq = '{OP_RELEASE, draw_owner(), 16'($urandom)};
				end else begin
					rq = '{OP_SPARE, 8'($urandom), 16'($urandom)};
				end
			end else if (full_left > 0) begin
				full_left--;
				if (r < 60)
					rq = (r < 15) ? draw_known(OP_ADD)
						: request_t'{OP_ADD, draw_owner(), 16'($urandom)};
				else if (r < 95)
					rq = draw_known(OP_LOOKUP);
				else
					rq = '{OP_SPARE, 8'($urandom), 16'($urandom)};
			end else begin
				if (r < 50)
					rq = (r < 15) ? draw_known(OP_ADD)
						: request_t'{OP_ADD, draw_owner(), 16'($urandom)};
				else if (r < 78)
					rq = (r < 64) ? draw_known(OP_LOOKUP)
						: request_t'{OP_LOOKUP, draw_owner(), 16'($urandom)};
				else if (r < 93)
					rq = '{OP_RELEASE, draw_owner(), 16'($urandom)};
				else
					rq = '{OP_SPARE, 8'($urandom), 16'($urandom)};
			end
			queue_request(rq.op, rq.owner, rq.page);
		end

		while (accepted_count < total_words)
			@(posedge clk);
		while (expected_outcomes.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
